### src/fpba_pkg.sv
package fpba_pkg;

  // default sizing
  localparam int unsigned DefMaxBlocks = 16;
  localparam int unsigned DefSizeBits  = 16;

  // port field widths
  localparam int unsigned FuncW  = 2;
  localparam int unsigned SizeW  = 16;
  localparam int unsigned StatW  = 2;
  localparam int unsigned BidxW  = 4;
  localparam int unsigned RemW   = 16;

  // request codes
  localparam logic [FuncW-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FuncW-1:0] FUNC_FIRST = 2'd1;
  localparam logic [FuncW-1:0] FUNC_BEST  = 2'd2;
  localparam logic [FuncW-1:0] FUNC_WORST = 2'd3;

  // result status codes
  localparam logic [StatW-1:0] ST_OK      = 2'd0;
  localparam logic [StatW-1:0] ST_NOSPACE = 2'd1;
  localparam logic [StatW-1:0] ST_EMPTY   = 2'd2;
  localparam logic [StatW-1:0] ST_FULL    = 2'd3;

endpackage

### src/fit_policy_block_allocator.sv
// channel | signals                                   | direction
// --------+-------------------------------------------+----------
// in      | in_valid_i, in_ready_o, func_i, size_i    | request
// out     | out_valid_o, out_ready_i, status_o,       | result
//         | block_index_o, remaining_o                |
//
// an add result goes through S_DONE into the result register; an allocation result follows a scan
// of every entry through the single table read port, plus a read and a write state for each
// entry moved up when the chosen block is used up.
// one item is in work at a time; in_ready_o is high only when the sequencer is idle.
// the result register holds its item until taken, so a stalled output holds the next one back.
// reset clears the sequencer and output registers but not the table; table entries are never read before written.
module fit_policy_block_allocator
  import fpba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = DefMaxBlocks,
  parameter int unsigned SIZE_BITS  = DefSizeBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [FuncW-1:0] func_i,
  input  logic [SizeW-1:0] size_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [StatW-1:0] status_o,
  output logic [BidxW-1:0] block_index_o,
  output logic [RemW-1:0]  remaining_o
);

  localparam int unsigned IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_BLOCKS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [FuncW-1:0]     func_q, func_d;
  logic [SIZE_BITS-1:0] req_q, req_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      issue_q, issue_d;
  logic                 cmp_v_q, cmp_v_d;
  logic [IdxW-1:0]      cmp_idx_q, cmp_idx_d;
  logic                 found_q, found_d;
  logic [IdxW-1:0]      pick_idx_q, pick_idx_d;
  logic [SIZE_BITS-1:0] pick_val_q, pick_val_d;
  logic [CntW-1:0]      j_q, j_d;
  logic [StatW-1:0]     res_stat_q, res_stat_d;
  logic [IdxW-1:0]      res_idx_q, res_idx_d;
  logic [SIZE_BITS-1:0] res_rem_q, res_rem_d;
  logic                 out_valid_q, out_valid_d;
  logic [StatW-1:0]     out_stat_q, out_stat_d;
  logic [IdxW-1:0]      out_idx_q, out_idx_d;
  logic [SIZE_BITS-1:0] out_rem_q, out_rem_d;

  // table memory, one write and one registered read per cycle
  logic [SIZE_BITS-1:0] mem_q [MAX_BLOCKS];
  logic [SIZE_BITS-1:0] rd_data_q;
  logic                 rd_en;
  logic [IdxW-1:0]      rd_addr;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  logic [SIZE_BITS-1:0] wr_data;

  logic                 in_acc;
  logic                 fits;
  logic                 take;
  logic [SIZE_BITS-1:0] rem_calc;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // shared compare and subtract unit
  assign fits = (rd_data_q >= req_q);
  assign take = fits && (!found_q
              || ((func_q == FUNC_BEST)  && (rd_data_q < pick_val_q))
              || ((func_q == FUNC_WORST) && (rd_data_q > pick_val_q)));
  assign rem_calc = pick_val_q - req_q;

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    req_d       = req_q;
    count_d     = count_q;
    issue_d     = issue_q;
    cmp_v_d     = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    pick_idx_d  = pick_idx_q;
    pick_val_d  = pick_val_q;
    j_d         = j_q;
    res_stat_d  = res_stat_q;
    res_idx_d   = res_idx_q;
    res_rem_d   = res_rem_q;
    out_valid_d = out_valid_q;
    out_stat_d  = out_stat_q;
    out_idx_d   = out_idx_q;
    out_rem_d   = out_rem_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          func_d  = func_i;
          req_d   = SIZE_BITS'(size_i);
          issue_d = '0;
          found_d = 1'b0;
          if (func_i == FUNC_ADD) begin
            state_d = S_DONE;
            if (count_q >= CntMax) begin
              res_stat_d = ST_FULL;
              res_idx_d  = '0;
              res_rem_d  = '0;
            end else begin
              wr_en      = 1'b1;
              wr_addr    = count_q[IdxW-1:0];
              wr_data    = SIZE_BITS'(size_i);
              res_stat_d = ST_OK;
              res_idx_d  = count_q[IdxW-1:0];
              res_rem_d  = SIZE_BITS'(size_i);
              count_d    = count_q + 1'b1;
            end
          end else if (count_q == '0) begin
            state_d    = S_DONE;
            res_stat_d = ST_EMPTY;
            res_idx_d  = '0;
            res_rem_d  = '0;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // issue the next read while the previous entry is compared
        if (issue_q < count_q) begin
          rd_en     = 1'b1;
          rd_addr   = issue_q[IdxW-1:0];
          cmp_v_d   = 1'b1;
          cmp_idx_d = issue_q[IdxW-1:0];
          issue_d   = issue_q + 1'b1;
        end
        if (cmp_v_q && take) begin
          found_d    = 1'b1;
          pick_idx_d = cmp_idx_q;
          pick_val_d = rd_data_q;
        end
        // scan finished, apply the pick
        if (!(issue_q < count_q) && !cmp_v_q) begin
          if (!found_q) begin
            state_d    = S_DONE;
            res_stat_d = ST_NOSPACE;
            res_idx_d  = '0;
            res_rem_d  = '0;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = pick_idx_q;
            wr_data    = rem_calc;
            res_stat_d = ST_OK;
            res_idx_d  = pick_idx_q;
            res_rem_d  = rem_calc;
            if (rem_calc == '0) begin
              count_d = count_q - 1'b1;
              j_d     = CntW'(pick_idx_q);
              state_d = S_SHIFT_RD;
            end else begin
              state_d = S_DONE;
            end
          end
        end
      end
      S_SHIFT_RD: begin
        // move later entries up one place
        if (j_q < count_q) begin
          rd_en   = 1'b1;
          rd_addr = IdxW'(j_q + 1'b1);
          state_d = S_SHIFT_WR;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = j_q[IdxW-1:0];
        wr_data = rd_data_q;
        j_d     = j_q + 1'b1;
        state_d = S_SHIFT_RD;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_stat_d  = res_stat_q;
          out_idx_d   = res_idx_q;
          out_rem_d   = res_rem_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      func_q      <= '0;
      req_q       <= '0;
      count_q     <= '0;
      issue_q     <= '0;
      cmp_v_q     <= 1'b0;
      cmp_idx_q   <= '0;
      found_q     <= 1'b0;
      pick_idx_q  <= '0;
      pick_val_q  <= '0;
      j_q         <= '0;
      res_stat_q  <= '0;
      res_idx_q   <= '0;
      res_rem_q   <= '0;
      out_valid_q <= 1'b0;
      out_stat_q  <= '0;
      out_idx_q   <= '0;
      out_rem_q   <= '0;
    end else begin
      state_q     <= state_d;
      func_q      <= func_d;
      req_q       <= req_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      cmp_v_q     <= cmp_v_d;
      cmp_idx_q   <= cmp_idx_d;
      found_q     <= found_d;
      pick_idx_q  <= pick_idx_d;
      pick_val_q  <= pick_val_d;
      j_q         <= j_d;
      res_stat_q  <= res_stat_d;
      res_idx_q   <= res_idx_d;
      res_rem_q   <= res_rem_d;
      out_valid_q <= out_valid_d;
      out_stat_q  <= out_stat_d;
      out_idx_q   <= out_idx_d;
      out_rem_q   <= out_rem_d;
    end
  end

  // table memory port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_stat_q;
  assign block_index_o = BidxW'(out_idx_q);
  assign remaining_o   = RemW'(out_rem_q);

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("block count above table depth");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (func_i == FUNC_ADD) && (count_q < CntMax))
    |=> (count_q == $past(count_q) + 1'b1))
    else $error("add did not grow the table");

  a_cmp_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && cmp_v_q) |-> (CntW'(cmp_idx_q) < count_q))
    else $error("scan compared an entry beyond the table");

  a_ok_pick_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && cmp_v_q && take) |-> (rd_data_q >= req_q))
    else $error("picked a block smaller than the request");
`endif

endmodule
